// ===== rtl/ets_pkg.sv =====
package ets_pkg;

	localparam int unsigned POS_BITS_DEFAULT = 16;
	localparam int unsigned WIDE_BITS        = 32;
	localparam int unsigned TOK_POS_BITS     = 16;
	localparam logic [TOK_POS_BITS-1:0] TOK_MAX = '1;

	localparam int unsigned MAX_TOKENS   = 4;
	localparam int unsigned TOK_CNT_BITS = $clog2(MAX_TOKENS + 1);
	localparam int unsigned TOK_IDX_BITS = $clog2(MAX_TOKENS);

	// character constants
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_MINUS  = "-";
	localparam logic [7:0] CH_STAR   = "*";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_COMMA  = ",";
	localparam logic [7:0] CH_DOT    = ".";
	localparam logic [7:0] CH_UNDER  = "_";
	localparam logic [7:0] CH_ZERO   = "0";
	localparam logic [7:0] CH_NINE   = "9";
	localparam logic [7:0] CH_LO_A   = "a";
	localparam logic [7:0] CH_LO_Z   = "z";
	localparam logic [7:0] CH_UP_A   = "A";
	localparam logic [7:0] CH_UP_Z   = "Z";
	localparam logic [7:0] CH_SPACE  = " ";
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// keywords, first character in the top byte
	localparam int unsigned KW_DEF_LEN    = 3;
	localparam int unsigned KW_EXTERN_LEN = 6;
	localparam logic [8*KW_DEF_LEN-1:0]    KW_DEF    = "def";
	localparam logic [8*KW_EXTERN_LEN-1:0] KW_EXTERN = "extern";

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_DOT,
		MODE_FRACTION,
		MODE_IDENT
	} mode_t;

	typedef enum logic [3:0] {
		KIND_PLUS,
		KIND_MINUS,
		KIND_STAR,
		KIND_SLASH,
		KIND_LPAREN,
		KIND_RPAREN,
		KIND_COMMA,
		KIND_NUMBER,
		KIND_IDENT,
		KIND_DEF,
		KIND_EXTERN,
		KIND_END,
		KIND_UNEXPECTED
	} kind_t;

	localparam logic [1:0] KW_ALIVE_ALL = 2'b11;

	typedef struct packed {
		mode_t      mode;
		logic [3:0] kw_prog;
		logic [1:0] kw_alive;
	} scan_ctl_t;

	localparam scan_ctl_t CTL_RESET = '{mode: MODE_IDLE, kw_prog: 4'd0, kw_alive: KW_ALIVE_ALL};

	typedef struct packed {
		kind_t                   kind;
		logic [TOK_POS_BITS-1:0] start;
		logic [TOK_POS_BITS-1:0] length;
		logic [7:0]              bad_char;
		logic                    last;
	} tok_t;

endpackage

// ===== rtl/ets_char_if.sv =====
interface ets_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       ch_valid;
	logic       end_of_source;

	modport source (output valid, ch, ch_valid, end_of_source, input ready);
	modport sink   (input valid, ch, ch_valid, end_of_source, output ready);
endinterface

// ===== rtl/ets_tok_if.sv =====
interface ets_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [7:0]  bad_char;
	logic        last_of_run;

	modport source (output valid, token_kind, token_start, token_length, bad_char,
		last_of_run, input ready);
	modport sink   (input valid, token_kind, token_start, token_length, bad_char,
		last_of_run, output ready);
endinterface

// ===== rtl/ets_step.sv =====
module ets_step
	import ets_pkg::*;
#(
	parameter int unsigned POSITION_BITS = POS_BITS_DEFAULT
) (
	input  logic [7:0]                   ch,
	input  logic                         ch_valid,
	input  logic                         end_of_source,
	input  scan_ctl_t                    ctl,
	input  logic [POSITION_BITS-1:0]     pos,
	input  logic [POSITION_BITS-1:0]     tok_begin,
	output scan_ctl_t                    ctl_nxt,
	output logic [POSITION_BITS-1:0]     pos_nxt,
	output logic [POSITION_BITS-1:0]     tok_begin_nxt,
	output tok_t [MAX_TOKENS-1:0]        toks,
	output logic [TOK_CNT_BITS-1:0]      n_toks
);

	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	typedef struct packed {
		tok_t       a;
		tok_t       b;
		logic [1:0] n;
	} fin_t;

	function automatic logic [TOK_POS_BITS-1:0] sat_tok(logic [POSITION_BITS-1:0] v);
		logic [WIDE_BITS-1:0] w;
		w = WIDE_BITS'(v);
		return (w > WIDE_BITS'(TOK_MAX)) ? TOK_MAX : w[TOK_POS_BITS-1:0];
	endfunction

	function automatic logic [POSITION_BITS-1:0] pdiff(logic [POSITION_BITS-1:0] a,
		logic [POSITION_BITS-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	function automatic tok_t mk_tok(kind_t k, logic [POSITION_BITS-1:0] s,
		logic [POSITION_BITS-1:0] l, logic [7:0] bad);
		tok_t t;
		t.kind     = k;
		t.start    = sat_tok(s);
		t.length   = sat_tok(l);
		t.bad_char = bad;
		t.last     = 1'b0;
		return t;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
			(c == CH_UNDER);
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// one identifier character against both keyword candidates
	function automatic scan_ctl_t kw_upd(scan_ctl_t c, logic [7:0] chr);
		scan_ctl_t r;
		logic      hit_def;
		logic      hit_ext;
		r       = c;
		hit_def = 1'b0;
		hit_ext = 1'b0;
		for (int i = 0; i < KW_DEF_LEN; i++) begin
			if (c.kw_prog == 4'(i) && chr == KW_DEF[8*(KW_DEF_LEN-1-i) +: 8]) hit_def = 1'b1;
		end
		for (int i = 0; i < KW_EXTERN_LEN; i++) begin
			if (c.kw_prog == 4'(i) && chr == KW_EXTERN[8*(KW_EXTERN_LEN-1-i) +: 8])
				hit_ext = 1'b1;
		end
		if (!hit_def) r.kw_alive[0] = 1'b0;
		if (!hit_ext) r.kw_alive[1] = 1'b0;
		if (c.kw_prog != 4'hF) r.kw_prog = c.kw_prog + 4'd1;
		return r;
	endfunction

	// close the open token; p is the position just past it
	function automatic fin_t finish(scan_ctl_t c, logic [POSITION_BITS-1:0] b,
		logic [POSITION_BITS-1:0] p);
		fin_t                     f;
		logic [POSITION_BITS-1:0] dp;
		kind_t                    k;
		f  = '0;
		dp = (p != '0) ? p - POS_ONE : '0;
		k  = KIND_IDENT;
		case (c.mode)
			MODE_NUMBER, MODE_FRACTION: begin
				f.a = mk_tok(KIND_NUMBER, b, pdiff(p, b), 8'h00);
				f.n = 2'd1;
			end
			MODE_DOT: begin
				f.a = mk_tok(KIND_NUMBER, b, pdiff(dp, b), 8'h00);
				f.b = mk_tok(KIND_UNEXPECTED, dp, POS_ONE, CH_DOT);
				f.n = 2'd2;
			end
			MODE_IDENT: begin
				if (c.kw_alive[0] && c.kw_prog == 4'(KW_DEF_LEN)) k = KIND_DEF;
				if (c.kw_alive[1] && c.kw_prog == 4'(KW_EXTERN_LEN)) k = KIND_EXTERN;
				f.a = mk_tok(k, b, pdiff(p, b), 8'h00);
				f.n = 2'd1;
			end
			default: ;
		endcase
		return f;
	endfunction

	fin_t  fin_ch;
	fin_t  fin_eos;
	logic  cont;
	kind_t op_kind;
	logic  is_op;

	always_comb begin
		is_op   = 1'b1;
		op_kind = KIND_PLUS;
		case (ch)
			CH_PLUS:   op_kind = KIND_PLUS;
			CH_MINUS:  op_kind = KIND_MINUS;
			CH_STAR:   op_kind = KIND_STAR;
			CH_SLASH:  op_kind = KIND_SLASH;
			CH_LPAREN: op_kind = KIND_LPAREN;
			CH_RPAREN: op_kind = KIND_RPAREN;
			CH_COMMA:  op_kind = KIND_COMMA;
			default:   is_op = 1'b0;
		endcase
	end

	always_comb begin
		ctl_nxt       = ctl;
		pos_nxt       = pos;
		tok_begin_nxt = tok_begin;
		toks          = '0;
		n_toks        = '0;
		cont          = 1'b0;
		fin_ch        = '0;
		fin_eos       = '0;

		if (ch_valid) begin
			case (ctl.mode)
				MODE_NUMBER: begin
					if (is_digit(ch)) begin
						cont = 1'b1;
					end else if (ch == CH_DOT) begin
						ctl_nxt.mode = MODE_DOT;
						cont         = 1'b1;
					end
				end
				MODE_DOT: begin
					if (is_digit(ch)) begin
						ctl_nxt.mode = MODE_FRACTION;
						cont         = 1'b1;
					end
				end
				MODE_FRACTION: begin
					if (is_digit(ch)) cont = 1'b1;
				end
				MODE_IDENT: begin
					if (is_word(ch) || is_digit(ch)) begin
						ctl_nxt = kw_upd(ctl, ch);
						cont    = 1'b1;
					end
				end
				default: ;
			endcase

			if (!cont) begin
				fin_ch = finish(ctl, tok_begin, pos);
				if (fin_ch.n != 2'd0) begin
					toks[n_toks[TOK_IDX_BITS-1:0]] = fin_ch.a;
					n_toks = n_toks + 1'b1;
				end
				if (fin_ch.n == 2'd2) begin
					toks[n_toks[TOK_IDX_BITS-1:0]] = fin_ch.b;
					n_toks = n_toks + 1'b1;
				end
				ctl_nxt.mode = MODE_IDLE;

				if (is_space(ch)) begin
					// skipped
				end else if (is_op) begin
					toks[n_toks[TOK_IDX_BITS-1:0]] = mk_tok(op_kind, pos, POS_ONE, 8'h00);
					n_toks = n_toks + 1'b1;
				end else if (is_digit(ch)) begin
					ctl_nxt.mode  = MODE_NUMBER;
					tok_begin_nxt = pos;
				end else if (is_word(ch)) begin
					ctl_nxt          = CTL_RESET;
					ctl_nxt          = kw_upd(ctl_nxt, ch);
					ctl_nxt.mode     = MODE_IDENT;
					tok_begin_nxt    = pos;
				end else begin
					toks[n_toks[TOK_IDX_BITS-1:0]] = mk_tok(KIND_UNEXPECTED, pos, POS_ONE, ch);
					n_toks = n_toks + 1'b1;
				end
			end

			pos_nxt = (pos == '1) ? pos : pos + POS_ONE;
		end

		if (end_of_source) begin
			fin_eos = finish(ctl_nxt, tok_begin_nxt, pos_nxt);
			if (fin_eos.n != 2'd0) begin
				toks[n_toks[TOK_IDX_BITS-1:0]] = fin_eos.a;
				n_toks = n_toks + 1'b1;
			end
			if (fin_eos.n == 2'd2) begin
				toks[n_toks[TOK_IDX_BITS-1:0]] = fin_eos.b;
				n_toks = n_toks + 1'b1;
			end
			toks[n_toks[TOK_IDX_BITS-1:0]] = mk_tok(KIND_END, pos_nxt, '0, 8'h00);
			n_toks        = n_toks + 1'b1;
			ctl_nxt       = CTL_RESET;
			pos_nxt       = '0;
			tok_begin_nxt = '0;
		end

		if (n_toks != '0) toks[TOK_IDX_BITS'(n_toks - 1'b1)].last = 1'b1;
	end

endmodule

// ===== rtl/expression_token_scanner.sv =====
// An accepted item is held in the input register until the burst register is free.
// Throughput: one item per cycle while items yield at most one token and the
//   receiver is ready; an item of k tokens (k up to 4) holds the token port until all k are taken.
// Tokens leave one per cycle from the burst register while the receiver is ready.
// Reset (arst_n low, asynchronous): scanner idle at position 0, no item held.
module expression_token_scanner
	import ets_pkg::*;
#(
	parameter int unsigned POSITION_BITS = POS_BITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	ets_char_if.sink        chars,
	ets_tok_if.source       tokens
);

	// input register
	logic                     valid_s1;
	logic [7:0]               ch_s1;
	logic                     ch_valid_s1;
	logic                     eos_s1;

	// scanner state
	scan_ctl_t                ctl_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] begin_q;

	// burst register: all tokens from one item, drained one per cycle while the receiver is ready
	tok_t [MAX_TOKENS-1:0]    burst_q;
	logic [TOK_CNT_BITS-1:0]  cnt_q;
	logic [TOK_IDX_BITS-1:0]  idx_q;
	logic                     busy_q;

	scan_ctl_t                ctl_nxt;
	logic [POSITION_BITS-1:0] pos_nxt;
	logic [POSITION_BITS-1:0] begin_nxt;
	tok_t [MAX_TOKENS-1:0]    toks;
	logic [TOK_CNT_BITS-1:0]  n_toks;

	logic                     in_take;
	logic                     out_take;
	logic                     last_take;
	logic                     burst_free;
	logic                     advance;
	tok_t                     cur;

	ets_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.ch            (ch_s1),
		.ch_valid      (ch_valid_s1),
		.end_of_source (eos_s1),
		.ctl           (ctl_q),
		.pos           (pos_q),
		.tok_begin     (begin_q),
		.ctl_nxt       (ctl_nxt),
		.pos_nxt       (pos_nxt),
		.tok_begin_nxt (begin_nxt),
		.toks          (toks),
		.n_toks        (n_toks)
	);

	// The burst register frees up in the cycle its last token is taken, so a
	// new item can move in behind it with no bubble.
	assign out_take   = busy_q && tokens.ready;
	assign last_take  = out_take && ({1'b0, idx_q} == TOK_CNT_BITS'(cnt_q - 1'b1));
	assign burst_free = !busy_q || last_take;
	assign advance    = valid_s1 && burst_free;

	assign chars.ready = !valid_s1 || burst_free;
	assign in_take     = chars.valid && chars.ready;

	assign cur                 = burst_q[idx_q];
	assign tokens.valid        = busy_q;
	assign tokens.token_kind   = cur.kind;
	assign tokens.token_start  = cur.start;
	assign tokens.token_length = cur.length;
	assign tokens.bad_char     = cur.bad_char;
	assign tokens.last_of_run  = cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1       <= chars.ch;
			ch_valid_s1 <= chars.ch_valid;
			eos_s1      <= chars.end_of_source;
		end
	end

	// scanner state moves only when the held item is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= CTL_RESET;
			pos_q   <= '0;
			begin_q <= '0;
		end else if (advance) begin
			ctl_q   <= ctl_nxt;
			pos_q   <= pos_nxt;
			begin_q <= begin_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (advance && n_toks != '0) begin
			busy_q <= 1'b1;
			cnt_q  <= n_toks;
			idx_q  <= '0;
		end else if (last_take) begin
			busy_q <= 1'b0;
		end else if (out_take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && n_toks != '0) burst_q <= toks;
	end

endmodule

// ===== rtl/ets_checker.sv =====
module ets_checker
	import ets_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [3:0]  kind,
	input logic [15:0] start,
	input logic [15:0] length,
	input logic [7:0]  bad,
	input logic        last
);

	// a stalled token holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(kind) && $stable(start) && $stable(length) &&
			$stable(bad) && $stable(last))
		else $error("token changed while stalled");

	// end of input is empty and closes its run
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_END |-> length == 16'd0 && last && bad == 8'h00)
		else $error("bad end token");

	// only unexpected tokens carry a character, always one long
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind != KIND_UNEXPECTED |-> bad == 8'h00)
		else $error("bad_char set on ordinary token");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind <= KIND_COMMA || kind == KIND_UNEXPECTED) |-> length == 16'd1)
		else $error("single character token with wrong length");

endmodule

bind expression_token_scanner ets_checker u_ets_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (tokens.valid),
	.ready  (tokens.ready),
	.kind   (tokens.token_kind),
	.start  (tokens.token_start),
	.length (tokens.token_length),
	.bad    (tokens.bad_char),
	.last   (tokens.last_of_run)
);

// ===== tb/sv/tb_expression_token_scanner.sv =====
module tb_expression_token_scanner;
	import ets_pkg::*;

	// The block is built with its default position width, so positions fit the
	// 16-bit token fields and never need clipping on the way out.
	localparam int unsigned   POS_W   = POS_BITS_DEFAULT;
	localparam logic [POS_W-1:0] POS_TOP = '1;
	localparam logic [POS_W-1:0] LEN_ONE = POS_W'(1);

	// one character item as the sender drives it
	typedef struct {
		logic [7:0] ch;
		logic       ch_valid;
		logic       end_of_source;
	} char_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #4 clk = ~clk;

	ets_char_if chars_if ();
	ets_tok_if  toks_if ();

	expression_token_scanner u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (toks_if)
	);

	// idling, in percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;

	// tokens still owed by the block, oldest first
	tok_t want_tokens[$];
	// tokens caused by the item being predicted
	tok_t item_tokens[$];
	// current random source text
	char_item_t src[$];

	// scanner state as the testbench tracks it
	mode_t            cur_mode;
	logic [POS_W-1:0] cur_pos;
	logic [POS_W-1:0] tok_from;
	logic [3:0]       kw_count;
	logic [1:0]       kw_live;

	string      def_word    = "def";
	string      extern_word = "extern";
	string      word_pool[12] = '{"def", "extern", "de", "ext", "exter", "defx",
		"externs", "d", "e", "DEF", "Extern", "_def"};
	logic [7:0] op_chars[7] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN,
		CH_RPAREN, CH_COMMA};

	// ---------------------------------------------------------------------
	// Token prediction
	// ---------------------------------------------------------------------

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	// space plus tab, LF, VT, FF and CR
	function automatic bit is_space(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// length between two positions; a negative span, possible once the
	// position has saturated, counts as zero
	function automatic logic [POS_W-1:0] span(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	// at most four tokens per item, surplus silently dropped
	function automatic void add_token(kind_t k, logic [POS_W-1:0] s, logic [POS_W-1:0] l,
		logic [7:0] bad);
		tok_t t;
		if (item_tokens.size() >= MAX_TOKENS) return;
		t.kind     = k;
		t.start    = s;
		t.length   = l;
		t.bad_char = bad;
		t.last     = 1'b0;
		item_tokens = {item_tokens, t};
	endfunction

	// keyword tracking: bit 0 of kw_live means def is still possible, bit 1 extern
	function automatic void kw_step(logic [7:0] c);
		int k;
		k = int'(kw_count);
		if (!(k < int'(KW_DEF_LEN) && c == def_word[k]))
			kw_live[0] = 1'b0;
		if (!(k < int'(KW_EXTERN_LEN) && c == extern_word[k]))
			kw_live[1] = 1'b0;
		if (kw_count != 4'hF)
			kw_count = kw_count + 1'b1;
	endfunction

	// emit the open token; p is the position just past it
	function automatic void close_token(logic [POS_W-1:0] p);
		logic [POS_W-1:0] dot_at;
		kind_t            k;
		dot_at = (p != '0) ? p - 1'b1 : '0;
		case (cur_mode)
			MODE_NUMBER, MODE_FRACTION: add_token(KIND_NUMBER, tok_from, span(p, tok_from), 8'd0);
			MODE_DOT: begin
				// held dot: the number stops before it, the dot is reported alone
				add_token(KIND_NUMBER, tok_from, span(dot_at, tok_from), 8'd0);
				add_token(KIND_UNEXPECTED, dot_at, LEN_ONE, CH_DOT);
			end
			MODE_IDENT: begin
				k = KIND_IDENT;
				if (kw_live[0] && kw_count == 4'(KW_DEF_LEN))
					k = KIND_DEF;
				if (kw_live[1] && kw_count == 4'(KW_EXTERN_LEN))
					k = KIND_EXTERN;
				add_token(k, tok_from, span(p, tok_from), 8'd0);
			end
			default: ;
		endcase
		cur_mode = MODE_IDLE;
	endfunction

	function automatic void open_token(logic [7:0] c, logic [POS_W-1:0] p);
		if (is_space(c)) return;
		case (c)
			CH_PLUS:   add_token(KIND_PLUS, p, LEN_ONE, 8'd0);
			CH_MINUS:  add_token(KIND_MINUS, p, LEN_ONE, 8'd0);
			CH_STAR:   add_token(KIND_STAR, p, LEN_ONE, 8'd0);
			CH_SLASH:  add_token(KIND_SLASH, p, LEN_ONE, 8'd0);
			CH_LPAREN: add_token(KIND_LPAREN, p, LEN_ONE, 8'd0);
			CH_RPAREN: add_token(KIND_RPAREN, p, LEN_ONE, 8'd0);
			CH_COMMA:  add_token(KIND_COMMA, p, LEN_ONE, 8'd0);
			default: begin
				if (is_digit(c)) begin
					cur_mode = MODE_NUMBER;
					tok_from = p;
				end else if (is_alpha(c) || c == CH_UNDER) begin
					cur_mode = MODE_IDENT;
					tok_from = p;
					kw_count = 4'd0;
					kw_live  = KW_ALIVE_ALL;
					kw_step(c);
				end else begin
					add_token(KIND_UNEXPECTED, p, LEN_ONE, c);
				end
			end
		endcase
	endfunction

	function automatic void take_char(logic [7:0] c, logic [POS_W-1:0] p);
		case (cur_mode)
			MODE_NUMBER: begin
				if (is_digit(c)) return;
				if (c == CH_DOT) begin
					cur_mode = MODE_DOT;
					return;
				end
			end
			MODE_DOT: begin
				if (is_digit(c)) begin
					cur_mode = MODE_FRACTION;
					return;
				end
			end
			MODE_FRACTION: begin
				if (is_digit(c)) return;
			end
			MODE_IDENT: begin
				if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
					kw_step(c);
					return;
				end
			end
			default: cur_mode = MODE_IDLE;
		endcase
		close_token(p);
		open_token(c, p);
	endfunction

	function automatic void clear_scan();
		cur_mode = MODE_IDLE;
		cur_pos  = '0;
		tok_from = '0;
		kw_count = 4'd0;
		kw_live  = KW_ALIVE_ALL;
	endfunction

	// work out the tokens that one accepted item causes and queue them
	function automatic void predict_item(logic [7:0] c, logic cv, logic eos);
		logic [POS_W-1:0] p;
		p = cur_pos;
		item_tokens.delete();
		if (cv) begin
			take_char(c, p);
			// position sticks at its top value
			cur_pos = (p != POS_TOP) ? p + 1'b1 : p;
		end
		if (eos) begin
			// flush, then end token; the next item starts a fresh source
			close_token(cur_pos);
			add_token(KIND_END, cur_pos, '0, 8'd0);
			clear_scan();
		end
		if (item_tokens.size() > 0)
			item_tokens[item_tokens.size() - 1].last = 1'b1;
		foreach (item_tokens[i])
			want_tokens = {want_tokens, item_tokens[i]};
	endfunction

	// ---------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------

	// Valid is left high after acceptance; the next call either keeps it high
	// with a fresh payload or drops it for a gap, so valid never sees two
	// assignments in one step.
	task automatic send_item(logic [7:0] c, logic cv, logic eos);
		if ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		chars_if.valid         <= 1'b1;
		chars_if.ch            <= c;
		chars_if.ch_valid      <= cv;
		chars_if.end_of_source <= eos;
		do @(posedge clk); while (!chars_if.ready);
		predict_item(c, cv, eos);
	endtask

	task automatic send_text(string s, bit eos_last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, eos_last && i == s.len() - 1);
	endtask

	// hold the sender off until every owed token has come out
	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (want_tokens.size() != 0);
	endtask

	// ---------------------------------------------------------------------
	// Receiver: random stalls, and the check of every accepted token
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		toks_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : tok_check
		tok_t got;
		tok_t want;
		if (arst_n && toks_if.valid && toks_if.ready) begin
			got.kind     = kind_t'(toks_if.token_kind);
			got.start    = toks_if.token_start;
			got.length   = toks_if.token_length;
			got.bad_char = toks_if.bad_char;
			got.last     = toks_if.last_of_run;
			if (want_tokens.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("ERROR token with none owed: kind %0d start %0d len %0d bad %02h last %0b",
						got.kind, got.start, got.length, got.bad_char, got.last);
			end else begin
				want = want_tokens.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"ERROR token: want kind %0d start %0d len %0d bad %02h last %0b,",
							" got kind %0d start %0d len %0d bad %02h last %0b"},
							want.kind, want.start, want.length, want.bad_char, want.last,
							got.kind, got.start, got.length, got.bad_char, got.last);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Random source text
	// ---------------------------------------------------------------------

	function automatic void push_ch(logic [7:0] c);
		char_item_t it;
		it.ch            = c;
		it.ch_valid      = 1'b1;
		it.end_of_source = 1'b0;
		src = {src, it};
	endfunction

	function automatic logic [7:0] space_char();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
	endfunction

	// letters and underscore can lead an identifier, digits only follow
	function automatic logic [7:0] ident_char(bit lead);
		int r;
		r = $urandom_range(lead ? 52 : 62);
		if (r < 26) return 8'(CH_LO_A + r);
		if (r < 52) return 8'(CH_UP_A + (r - 26));
		if (r == 52) return CH_UNDER;
		return 8'(CH_ZERO + (r - 53));
	endfunction

	// Mostly well-formed token runs with random content, salted with stray
	// dots, noise bytes and ignored items; always closed by an end of source.
	function automatic void build_source();
		int         n_tok;
		int         n;
		string      w;
		char_item_t it;
		src.delete();
		n_tok = $urandom_range(1, 8);
		for (int t = 0; t < n_tok; t++) begin
			case ($urandom_range(11))
				0, 1, 2: begin
					n = $urandom_range(1, 4);
					repeat (n) push_ch(8'(CH_ZERO + $urandom_range(9)));
					case ($urandom_range(3))
						0: begin
							push_ch(CH_DOT);
							repeat ($urandom_range(1, 3)) push_ch(8'(CH_ZERO + $urandom_range(9)));
						end
						1: push_ch(CH_DOT);
						default: ;
					endcase
				end
				3, 4, 5: begin
					if ($urandom_range(1)) begin
						w = word_pool[$urandom_range(11)];
						for (int i = 0; i < w.len(); i++)
							push_ch(w[i]);
					end else begin
						// long enough now and then to saturate the keyword count
						n = $urandom_range(1, 18);
						for (int i = 0; i < n; i++)
							push_ch(ident_char(i == 0));
					end
				end
				6, 7: push_ch(op_chars[$urandom_range(6)]);
				8: repeat ($urandom_range(1, 3)) push_ch(space_char());
				9: push_ch(8'($urandom_range(255)));
				10: push_ch(CH_DOT);
				default: begin
					it.ch            = 8'($urandom_range(255));
					it.ch_valid      = 1'b0;
					it.end_of_source = 1'b0;
					src = {src, it};
				end
			endcase
			if ($urandom_range(9) < 7)
				push_ch(space_char());
		end
		// end flag rides on the last character or comes as a bare marker
		if ($urandom_range(1) && src[$].ch_valid) begin
			src[$].end_of_source = 1'b1;
		end else begin
			it.ch            = 8'($urandom_range(255));
			it.ch_valid      = 1'b0;
			it.end_of_source = 1'b1;
			src = {src, it};
		end
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// every operator, both keywords, a fraction, underscore identifier
	task automatic test_operators_keywords();
		send_text("(def+4.5*extern-x1/_,)", 1'b1);
	endtask

	// dot followed by a non-digit (three tokens from one item), then a dot
	// arriving together with the end of source
	task automatic test_dot_lookahead();
		send_text("3.)7.", 1'b1);
		// held dot, then an operator with end: four tokens from one item
		send_text("1.", 1'b0);
		send_item(CH_PLUS, 1'b1, 1'b1);
	endtask

	// byte extremes as unexpected characters, an ignored item, a bare end
	task automatic test_byte_extremes();
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);
	endtask

	task automatic test_random_sources(int send_pct, int recv_pct, int n_items);
		int sent;
		sent           = 0;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		while (sent < n_items) begin
			build_source();
			foreach (src[i]) begin
				send_item(src[i].ch, src[i].ch_valid, src[i].end_of_source);
				sent++;
			end
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------

	initial begin
		chars_if.valid         = 1'b0;
		chars_if.ch            = 8'd0;
		chars_if.ch_valid      = 1'b0;
		chars_if.end_of_source = 1'b0;
		toks_if.ready          = 1'b0;
		clear_scan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_operators_keywords();
		test_dot_lookahead();
		test_byte_extremes();
		// sender held off until the block has nothing left to say
		wait_drained();
		test_random_sources(0, 0, 60);
		test_random_sources(57, 0, 60);
		test_random_sources(0, 57, 60);
		test_random_sources(12, 12, 60);

		// allow for any stray token after the last owed one
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#8000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
